>>> rtl/ihs_pkg.sv
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared lane codes and the side-band struct that travels with each pixel
// through the pan-fusion pipeline.
// ----------------------------------------------------------------------------
package ihs_pkg;

    // color lanes, processed side by side
    localparam int LANES  = 3;
    localparam int LANE_B = 0;
    localparam int LANE_G = 1;
    localparam int LANE_R = 2;

    // per-item control carried alongside the data
    typedef struct packed {
        logic             last;   // end-of-image marker
        logic             zero;   // channel sum is zero
        logic [LANES-1:0] ovf;    // quotient would exceed the sample range
    } t_side;

endpackage

>>> rtl/ihs_pre.sv
// ----------------------------------------------------------------------------
// ihs_pre
// Front of the pipeline: stage one forms pan*channel and the channel sum,
// stage two scales to 3*pan*channel and flags zero sum and overflow.
// ----------------------------------------------------------------------------
module ihs_pre #(
    parameter int W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_en,
    input  logic                 i_valid,
    input  logic [W-1:0]         i_blue,
    input  logic [W-1:0]         i_green,
    input  logic [W-1:0]         i_red,
    input  logic [W-1:0]         i_pan,
    input  logic                 i_last,
    output logic [1:0]           o_valid,
    output logic [2*W+1:0]       o_num [ihs_pkg::LANES],
    output logic [W+1:0]         o_sum,
    output logic [W-1:0]         o_pan,
    output ihs_pkg::t_side       o_side
);
    import ihs_pkg::*;

    localparam int RW = 2*W + 2;

    logic [W-1:0]   chan    [LANES];
    logic [2*W-1:0] n_prod  [LANES];
    logic [RW-1:0]  n_num   [LANES];
    logic [W+1:0]   n_sum;
    logic [RW-1:0]  bound;
    t_side          n_side;

    logic           r1_valid;
    logic [2*W-1:0] r1_prod [LANES];
    logic [W+1:0]   r1_sum;
    logic [W-1:0]   r1_pan;
    logic           r1_last;

    logic           r2_valid;
    logic [RW-1:0]  r2_num  [LANES];
    logic [W+1:0]   r2_sum;
    logic [W-1:0]   r2_pan;
    t_side          r2_side;

    // stage one: products and sum
    always_comb begin
        chan[LANE_B] = i_blue;
        chan[LANE_G] = i_green;
        chan[LANE_R] = i_red;
        for (int l = 0; l < LANES; l++) begin
            n_prod[l] = (2*W)'(i_pan) * (2*W)'(chan[l]);
        end
        n_sum = (W+2)'(i_blue) + (W+2)'(i_green) + (W+2)'(i_red);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en[0]) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_prod <= n_prod;
            r1_sum  <= n_sum;
            r1_pan  <= i_pan;
            r1_last <= i_last;
        end
    end

    // stage two: times three, overflow when 3*pan*c >= sum * 2^W
    always_comb begin
        bound       = RW'(r1_sum) << W;
        n_side.last = r1_last;
        n_side.zero = (r1_sum == '0);
        for (int l = 0; l < LANES; l++) begin
            n_num[l]      = RW'({r1_prod[l], 1'b0}) + RW'(r1_prod[l]);
            n_side.ovf[l] = (n_num[l] >= bound);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en[1]) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_num  <= n_num;
            r2_sum  <= r1_sum;
            r2_pan  <= r1_pan;
            r2_side <= n_side;
        end
    end

    assign o_valid = {r2_valid, r1_valid};
    assign o_num   = r2_num;
    assign o_sum   = r2_sum;
    assign o_pan   = r2_pan;
    assign o_side  = r2_side;

endmodule

>>> rtl/ihs_div_step.sv
// ----------------------------------------------------------------------------
// ihs_div_step
// One restoring-division stage: decides quotient bit BIT for all three lanes
// against the shared divisor and registers the partial remainder.
// ----------------------------------------------------------------------------
module ihs_div_step #(
    parameter int W   = 8,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2*W+1:0]       i_rem  [ihs_pkg::LANES],
    input  logic [W-1:0]         i_quo  [ihs_pkg::LANES],
    input  logic [W+1:0]         i_sum,
    input  logic [W-1:0]         i_pan,
    input  ihs_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic [2*W+1:0]       o_rem  [ihs_pkg::LANES],
    output logic [W-1:0]         o_quo  [ihs_pkg::LANES],
    output logic [W+1:0]         o_sum,
    output logic [W-1:0]         o_pan,
    output ihs_pkg::t_side       o_side
);
    import ihs_pkg::*;

    localparam int RW = 2*W + 2;

    logic [RW-1:0] dsh;
    logic [RW-1:0] n_rem [LANES];
    logic [W-1:0]  n_quo [LANES];
    logic          ge    [LANES];

    logic          r_valid;
    logic [RW-1:0] r_rem [LANES];
    logic [W-1:0]  r_quo [LANES];
    logic [W+1:0]  r_sum;
    logic [W-1:0]  r_pan;
    t_side         r_side;

    // trial subtract of sum << BIT
    always_comb begin
        dsh = RW'(i_sum) << BIT;
        for (int l = 0; l < LANES; l++) begin
            ge[l]         = (i_rem[l] >= dsh);
            n_rem[l]      = ge[l] ? (i_rem[l] - dsh) : i_rem[l];
            n_quo[l]      = i_quo[l];
            n_quo[l][BIT] = ge[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_sum  <= i_sum;
            r_pan  <= i_pan;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_sum   = r_sum;
    assign o_pan   = r_pan;
    assign o_side  = r_side;

endmodule

>>> rtl/ihs_pan_fusion_pixel_top.sv
// ----------------------------------------------------------------------------
// ihs_pan_fusion_pixel_top
// Triangle-model IHS pan-sharpening of one pixel: each channel becomes
// min(floor(3*pan*c/(B+G+R)), max), or pan when all channels are zero.
// ----------------------------------------------------------------------------
// Path: the ihs_pre stages, the divider stages, then the output register.
// Throughput: one pixel per cycle unless stalled; the restoring divider
//   resolves one quotient bit per stage, so its depth equals SAMPLE_BITS.
// Stalls fill empty stages first; each stage holds its item until it moves.
// Reset: clears the stage valid bits only; no other state.
// ----------------------------------------------------------------------------
module ihs_pan_fusion_pixel_top #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_blue_in,
    input  logic [SAMPLE_BITS-1:0] i_green_in,
    input  logic [SAMPLE_BITS-1:0] i_red_in,
    input  logic [SAMPLE_BITS-1:0] i_pan_in,
    input  logic                   i_last_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_blue_out,
    output logic [SAMPLE_BITS-1:0] o_green_out,
    output logic [SAMPLE_BITS-1:0] o_red_out,
    output logic                   o_last_out
);
    import ihs_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int RW = 2*W + 2;
    localparam int S  = W + 3;      // total register stages

    logic [S-1:0]  v;
    logic [S:0]    en;

    logic [RW-1:0] rem_s  [W+1][LANES];
    logic [W-1:0]  quo_s  [W+1][LANES];
    logic [W+1:0]  sum_s  [W+1];
    logic [W-1:0]  pan_s  [W+1];
    t_side         side_s [W+1];
    logic          vld_s  [W+1];

    logic [W-1:0]  n_res  [LANES];
    logic          r_out_valid;
    logic [W-1:0]  r_res  [LANES];
    logic          r_last;

    // a stage may load when it is empty or its item moves on
    assign en[S] = i_out_ready;
    for (genvar k = 0; k < S; k++) begin : g_en
        assign en[k] = ~v[k] | en[k+1];
    end
    assign o_in_ready = en[0];

    // front stages
    ihs_pre #(
        .W (W)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[1:0]),
        .i_valid (i_in_valid),
        .i_blue  (i_blue_in),
        .i_green (i_green_in),
        .i_red   (i_red_in),
        .i_pan   (i_pan_in),
        .i_last  (i_last_in),
        .o_valid (v[1:0]),
        .o_num   (rem_s[0]),
        .o_sum   (sum_s[0]),
        .o_pan   (pan_s[0]),
        .o_side  (side_s[0])
    );

    for (genvar l = 0; l < LANES; l++) begin : g_quo0
        assign quo_s[0][l] = '0;
    end
    assign vld_s[0] = v[1];

    // divider: one quotient bit per stage, MSB first
    for (genvar k = 0; k < W; k++) begin : g_div
        ihs_div_step #(
            .W   (W),
            .BIT (W - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[k+2]),
            .i_valid (vld_s[k]),
            .i_rem   (rem_s[k]),
            .i_quo   (quo_s[k]),
            .i_sum   (sum_s[k]),
            .i_pan   (pan_s[k]),
            .i_side  (side_s[k]),
            .o_valid (vld_s[k+1]),
            .o_rem   (rem_s[k+1]),
            .o_quo   (quo_s[k+1]),
            .o_sum   (sum_s[k+1]),
            .o_pan   (pan_s[k+1]),
            .o_side  (side_s[k+1])
        );
        assign v[k+2] = vld_s[k+1];
    end

    // output select: zero sum passes pan, overflow clamps
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (side_s[W].zero) begin
                n_res[l] = pan_s[W];
            end else if (side_s[W].ovf[l]) begin
                n_res[l] = '1;
            end else begin
                n_res[l] = quo_s[W][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en[S-1]) begin
            r_out_valid <= v[S-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S-1]) begin
            r_res  <= n_res;
            r_last <= side_s[W].last;
        end
    end

    assign v[S-1]      = r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_blue_out  = r_res[LANE_B];
    assign o_green_out = r_res[LANE_G];
    assign o_red_out   = r_res[LANE_R];
    assign o_last_out  = r_last;

    // empty pipeline always takes an item
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v == '0) |-> o_in_ready)
        else $error("pipeline empty but input not ready");

    // occupancy tracks accepted items in and out
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(v) == $past($countones(v))
            + int'($past(i_in_valid && o_in_ready))
            - int'($past(o_out_valid && i_out_ready))))
        else $error("item lost or duplicated in pipeline");

    // final remainder is below the divisor on every lane in range
    a_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld_s[W] && !side_s[W].zero) |->
        ((side_s[W].ovf[LANE_B] || rem_s[W][LANE_B] < RW'(sum_s[W])) &&
         (side_s[W].ovf[LANE_G] || rem_s[W][LANE_G] < RW'(sum_s[W])) &&
         (side_s[W].ovf[LANE_R] || rem_s[W][LANE_R] < RW'(sum_s[W]))))
        else $error("divider remainder not below divisor");

endmodule
